// ===== sv/pwbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwbs_pkg
// Shared types and constants for the pulse-width one-wire byte sender.
// ----------------------------------------------------------------------------
package pwbs_pkg;

  localparam int unsigned BitsPerFrameDef = 8;
  localparam int unsigned PeriodW         = 16;
  localparam int unsigned DataW           = 8;
  localparam int unsigned AddrW           = 4;
  localparam int unsigned ApbDataW        = 32;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] RegStartLow  = 2'd0;
  localparam logic [1:0] RegLongPhase = 2'd1;
  localparam logic [1:0] RegShortPhase = 2'd2;
  localparam logic [1:0] RegStopHigh  = 2'd3;

  localparam logic [PeriodW-1:0] StartLowRst   = 16'd500;
  localparam logic [PeriodW-1:0] LongPhaseRst  = 16'd120;
  localparam logic [PeriodW-1:0] ShortPhaseRst = 16'd40;
  localparam logic [PeriodW-1:0] StopHighRst   = 16'd40;

  // input word kinds
  localparam logic OpTick = 1'b0;
  localparam logic OpSend = 1'b1;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_START = 5'b00010,
    PH_HIGH  = 5'b00100,
    PH_LOW   = 5'b01000,
    PH_STOP  = 5'b10000
  } pwbs_phase_e;

  typedef struct packed {
    logic [PeriodW-1:0] start_low;
    logic [PeriodW-1:0] long_phase;
    logic [PeriodW-1:0] short_phase;
    logic [PeriodW-1:0] stop_high;
  } pwbs_cfg_t;

  typedef struct packed {
    logic frame_done;
    logic send_accepted;
    logic busy_res;
    logic line_level;
  } pwbs_res_t;

  // a programmed zero counts as one tick
  function automatic logic [PeriodW-1:0] period_of(input logic [PeriodW-1:0] r);
    period_of = (r == '0) ? PeriodW'(1) : r;
  endfunction

endpackage

// ===== sv/pwbs_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwbs_cfg_regs
// APB register file holding the four frame timing periods.
// ----------------------------------------------------------------------------
module pwbs_cfg_regs
  import pwbs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output pwbs_cfg_t           cfg_o
);

  pwbs_cfg_t   cfg_q;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_low   <= StartLowRst;
      cfg_q.long_phase  <= LongPhaseRst;
      cfg_q.short_phase <= ShortPhaseRst;
      cfg_q.stop_high   <= StopHighRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegStartLow:   cfg_q.start_low   <= pwdata[PeriodW-1:0];
        RegLongPhase:  cfg_q.long_phase  <= pwdata[PeriodW-1:0];
        RegShortPhase: cfg_q.short_phase <= pwdata[PeriodW-1:0];
        RegStopHigh:   cfg_q.stop_high   <= pwdata[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegStartLow:   prdata = ApbDataW'(cfg_q.start_low);
      RegLongPhase:  prdata = ApbDataW'(cfg_q.long_phase);
      RegShortPhase: prdata = ApbDataW'(cfg_q.short_phase);
      RegStopHigh:   prdata = ApbDataW'(cfg_q.stop_high);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/pwbs_frame_fsm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwbs_frame_fsm
// Frame sequencer: applies one tick or send word per step and reports status.
// ----------------------------------------------------------------------------
module pwbs_frame_fsm
  import pwbs_pkg::*;
#(
  parameter int unsigned BITS_PER_FRAME = BitsPerFrameDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             op_i,
  input  logic [DataW-1:0] data_i,
  input  pwbs_cfg_t        cfg_i,
  output pwbs_res_t        res_o
);

  localparam int unsigned CntW = $clog2(BITS_PER_FRAME + 1);
  localparam logic [CntW-1:0] LastBit = CntW'(BITS_PER_FRAME - 1);

  pwbs_phase_e        phase_q, phase_d;
  logic [PeriodW-1:0] ticks_q, ticks_d;
  logic [DataW-1:0]   shift_q, shift_d;
  logic [CntW-1:0]    sent_q, sent_d;
  logic               line_q, line_d;
  logic [PeriodW-1:0] ticks_dec;
  logic               accepted, done;

  always_comb begin
    phase_d   = phase_q;
    ticks_d   = ticks_q;
    shift_d   = shift_q;
    sent_d    = sent_q;
    line_d    = line_q;
    accepted  = 1'b0;
    done      = 1'b0;
    ticks_dec = (ticks_q != '0) ? ticks_q - PeriodW'(1) : '0;

    if (op_i == OpSend) begin
      if (phase_q == PH_IDLE) begin
        accepted = 1'b1;
        shift_d  = data_i;
        sent_d   = '0;
        line_d   = 1'b0;
        phase_d  = PH_START;
        ticks_d  = period_of(cfg_i.start_low);
      end
    end else if (phase_q != PH_IDLE) begin
      ticks_d = ticks_dec;
      if (ticks_dec == '0) begin
        unique case (phase_q)
          PH_START: begin
            line_d  = 1'b1;
            phase_d = PH_HIGH;
            ticks_d = shift_q[0] ? period_of(cfg_i.long_phase)
                                 : period_of(cfg_i.short_phase);
          end
          PH_HIGH: begin
            line_d  = 1'b0;
            phase_d = PH_LOW;
            ticks_d = shift_q[0] ? period_of(cfg_i.short_phase)
                                 : period_of(cfg_i.long_phase);
          end
          PH_LOW: begin
            shift_d = {1'b0, shift_q[DataW-1:1]};
            sent_d  = sent_q + CntW'(1);
            line_d  = 1'b1;
            if (sent_q == LastBit) begin
              phase_d = PH_STOP;
              ticks_d = period_of(cfg_i.stop_high);
            end else begin
              // next bit cell looks at the bit just shifted down
              phase_d = PH_HIGH;
              ticks_d = shift_q[1] ? period_of(cfg_i.long_phase)
                                   : period_of(cfg_i.short_phase);
            end
          end
          PH_STOP: begin
            line_d  = 1'b1;
            phase_d = PH_IDLE;
            ticks_d = '0;
            sent_d  = '0;
            done    = 1'b1;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      ticks_q <= '0;
      shift_q <= '0;
      sent_q  <= '0;
      line_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      ticks_q <= ticks_d;
      shift_q <= shift_d;
      sent_q  <= sent_d;
      line_q  <= line_d;
    end
  end

  assign res_o.line_level    = line_d;
  assign res_o.busy_res      = (phase_d != PH_IDLE);
  assign res_o.send_accepted = accepted;
  assign res_o.frame_done    = done;

endmodule

// ===== sv/pulse_width_one_wire_byte_sender_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_width_one_wire_byte_sender_core
// Pulse-width one-wire byte sender with stream in/out and APB timing regs.
// ----------------------------------------------------------------------------
// Input words carry either a 10 us time tick or a request to send a byte
// (s_axis_tuser). A send is taken only while idle; a send while a frame runs
// returns a word with send_accepted low and changes nothing. A frame is a
// start low period, BITS_PER_FRAME bit cells LSB first (one = long high,
// short low; zero = short high, long low) and a stop high period.
// Every input word yields exactly one output word with the line level,
// busy flag, send-accepted flag and frame-done flag after that word.
// Each word passes the input register, then the result register, before it is
// offered on the master stream.
// Throughput: one word per cycle while m_axis_tready stays high; the sequencer
// step is a single pass of decrement, compare and phase select.
// When m_axis_tready is low the result register holds its word and the
// input register still takes one more word; after that s_axis_tready drops.
// Reset brings the line low, the sequencer idle and the timing registers to
// 500/120/40/40 ticks. The user writes timing registers only with no word in flight.
// ----------------------------------------------------------------------------
module pulse_width_one_wire_byte_sender_core
  import pwbs_pkg::*;
#(
  parameter int unsigned BITS_PER_FRAME = BitsPerFrameDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [DataW-1:0]    s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]          s_axis_tuser,   // [0] operation
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] line_level, [1] busy_res, [2] send_accepted, [3] frame_done, [7:4] 0
  output logic [7:0]          m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  pwbs_cfg_t        cfg;
  pwbs_res_t        res;
  logic             in_valid_q;
  logic             in_op_q;
  logic [DataW-1:0] in_data_q;
  logic             out_valid_q;
  pwbs_res_t        out_res_q;
  logic             advance;

  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q   <= s_axis_tuser[0];
      in_data_q <= s_axis_tdata;
    end
  end

  pwbs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pwbs_frame_fsm #(
    .BITS_PER_FRAME (BITS_PER_FRAME)
  ) u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .op_i   (in_op_q),
    .data_i (in_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_res_q.frame_done, out_res_q.send_accepted,
                          out_res_q.busy_res, out_res_q.line_level};

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for the pulse-width one-wire byte sender core.
// ----------------------------------------------------------------------------
// Tick and send words go in on the slave stream. Each accepted word runs
// through a local copy of the frame sequencer, which queues the status word
// it expects. Every word on the master stream is checked field by field
// against the oldest queued status. Timing registers are written over APB
// while no word is in flight. Both streams idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import pwbs_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [DataW-1:0]    s_axis_tdata;   // [7:0] data_byte
  logic [0:0]          s_axis_tuser;   // [0] operation
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // [0] line_level, [1] busy_res, [2] send_accepted, [3] frame_done, [7:4] 0
  logic [7:0]          m_axis_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  pulse_width_one_wire_byte_sender_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // local copy of timing registers and sequencer state
  pwbs_cfg_t          timing = '{StartLowRst, LongPhaseRst, ShortPhaseRst, StopHighRst};
  pwbs_phase_e        ph       = PH_IDLE;
  logic [PeriodW-1:0] tick_cnt = '0;
  logic [7:0]         shift_q  = '0;
  logic [5:0]         bit_cnt  = '0;
  logic               line_q   = 1'b0;

  pwbs_res_t line_status_q[$];
  int unsigned mismatch_cnt = 0;
  bit gaps_on;
  bit stalls_on;
  int stall_left = 0;

  function automatic logic [PeriodW-1:0] ticks_of(logic [PeriodW-1:0] r);
    return (r == '0) ? PeriodW'(1) : r;
  endfunction

  function automatic void start_cell();
    line_q   = 1'b1;
    ph       = PH_HIGH;
    tick_cnt = shift_q[0] ? ticks_of(timing.long_phase) : ticks_of(timing.short_phase);
  endfunction

  // applies one word to the local sequencer, returns the status it yields
  function automatic pwbs_res_t advance_line(logic op, logic [7:0] data);
    pwbs_res_t r;
    r = '0;
    if (op == OpSend) begin
      if (ph == PH_IDLE) begin
        r.send_accepted = 1'b1;
        shift_q  = data;
        bit_cnt  = '0;
        line_q   = 1'b0;
        ph       = PH_START;
        tick_cnt = ticks_of(timing.start_low);
      end
    end else if (ph != PH_IDLE) begin
      if (tick_cnt != '0) tick_cnt = tick_cnt - PeriodW'(1);
      if (tick_cnt == '0) begin
        case (ph)
          PH_START: start_cell();
          PH_HIGH: begin
            line_q   = 1'b0;
            ph       = PH_LOW;
            tick_cnt = shift_q[0] ? ticks_of(timing.short_phase)
                                  : ticks_of(timing.long_phase);
          end
          PH_LOW: begin
            shift_q = shift_q >> 1;
            bit_cnt = bit_cnt + 6'd1;
            if (bit_cnt >= 6'(BitsPerFrameDef)) begin
              line_q   = 1'b1;
              ph       = PH_STOP;
              tick_cnt = ticks_of(timing.stop_high);
            end else begin
              start_cell();
            end
          end
          default: begin
            line_q          = 1'b1;
            ph              = PH_IDLE;
            tick_cnt        = '0;
            bit_cnt         = '0;
            r.frame_done    = 1'b1;
          end
        endcase
      end
    end
    r.line_level = line_q;
    r.busy_res   = (ph != PH_IDLE);
    return r;
  endfunction

  task automatic send_word(logic op, logic [7:0] data);
    int gap;
    int pick;
    gap  = 0;
    pick = $urandom_range(0, 99);
    if (gaps_on && pick >= 50) gap = (pick < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = data;
    do @(posedge clk_i); while (!s_axis_tready);
    line_status_q.push_back(advance_line(op, data));
  endtask

  task automatic set_period(logic [1:0] idx, logic [PeriodW-1:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {16'($urandom), val};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegStartLow:   timing.start_low   = val;
      RegLongPhase:  timing.long_phase  = val;
      RegShortPhase: timing.short_phase = val;
      default:       timing.stop_high   = val;
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // stop sending and let every queued status come back
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (line_status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_to_idle();
    while (ph != PH_IDLE) send_word(OpTick, 8'($urandom));
  endtask

  function automatic logic [PeriodW-1:0] rand_period();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return '0;
    if (pick < 80) return PeriodW'($urandom_range(1, 4));
    if (pick < 95) return PeriodW'($urandom_range(5, 20));
    return PeriodW'($urandom_range(100, 300));
  endfunction

  // reset start period of 500 ticks, line low until the start period ends
  task automatic test_reset_timing();
    send_word(OpTick, 8'h00);
    send_word(OpTick, 8'hFF);
    send_word(OpSend, 8'hC3);
    send_word(OpSend, 8'h3C);  // rejected while busy
    repeat (10) send_word(OpTick, 8'($urandom));
    // shorter bit cells while the start period is still running
    wait_drained();
    set_period(RegLongPhase, 16'd2);
    set_period(RegShortPhase, 16'd1);
    set_period(RegStopHigh, 16'd3);
    run_to_idle();
    send_word(OpTick, 8'h55);
  endtask

  task automatic test_directed();
    wait_drained();
    set_period(RegStartLow, 16'd2);
    set_period(RegLongPhase, 16'd3);
    set_period(RegShortPhase, 16'd1);
    set_period(RegStopHigh, 16'd2);
    send_word(OpSend, 8'hFF);
    send_word(OpTick, 8'h00);
    send_word(OpSend, 8'h00);
    run_to_idle();
    send_word(OpSend, 8'h00);
    run_to_idle();
    send_word(OpTick, 8'hAA);
    // timing change in the middle of a frame, picked up at the next load
    send_word(OpSend, 8'h96);
    repeat (4) send_word(OpTick, 8'($urandom));
    wait_drained();
    set_period(RegLongPhase, 16'd5);
    set_period(RegShortPhase, 16'd2);
    run_to_idle();
    // programmed zero counts as one tick
    wait_drained();
    set_period(RegStartLow, 16'd0);
    set_period(RegLongPhase, 16'd0);
    set_period(RegShortPhase, 16'd0);
    set_period(RegStopHigh, 16'd0);
    send_word(OpSend, 8'h5A);
    run_to_idle();
  endtask

  task automatic test_long_periods();
    wait_drained();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    set_period(RegStartLow, 16'd60);
    set_period(RegLongPhase, 16'd0);
    set_period(RegShortPhase, 16'd1);
    set_period(RegStopHigh, 16'd60);
    send_word(OpSend, 8'h81);
    run_to_idle();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_random();
    int pick;
    for (int p = 0; p < 5; p++) begin
      wait_drained();
      set_period(RegStartLow, rand_period());
      set_period(RegLongPhase, rand_period());
      set_period(RegShortPhase, rand_period());
      set_period(RegStopHigh, rand_period());
      gaps_on   = (p != 2);
      stalls_on = (p != 3);
      repeat (50) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) send_word(OpSend, 8'($urandom));
        else send_word(OpTick, 8'($urandom));
      end
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    run_to_idle();
  endtask

  // result-side backpressure
  always @(negedge clk_i) begin
    if (!stalls_on) begin
      m_axis_tready = 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready = 1'b0;
      stall_left    = stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      m_axis_tready = 1'b0;
      stall_left    = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  function automatic void flag_mismatch(string field, int unsigned want, int unsigned got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
  endfunction

  always @(posedge clk_i) begin
    pwbs_res_t want;
    pwbs_res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = pwbs_res_t'(m_axis_tdata[3:0]);
      if (line_status_q.size() == 0) begin
        flag_mismatch("unexpected word", 0, 32'(m_axis_tdata));
      end else begin
        want = line_status_q.pop_front();
        if (got.line_level !== want.line_level)
          flag_mismatch("line_level", 32'(want.line_level), 32'(got.line_level));
        if (got.busy_res !== want.busy_res)
          flag_mismatch("busy_res", 32'(want.busy_res), 32'(got.busy_res));
        if (got.send_accepted !== want.send_accepted)
          flag_mismatch("send_accepted", 32'(want.send_accepted), 32'(got.send_accepted));
        if (got.frame_done !== want.frame_done)
          flag_mismatch("frame_done", 32'(want.frame_done), 32'(got.frame_done));
        if (m_axis_tdata[7:4] !== 4'h0)
          flag_mismatch("pad bits", 0, 32'(m_axis_tdata[7:4]));
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OpTick;
    m_axis_tready = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    gaps_on       = 1'b1;
    stalls_on     = 1'b1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_timing();
    test_directed();
    test_long_periods();
    test_random();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && line_status_q.size() == 0) begin
      $display("pulse_width_one_wire_byte_sender_core regression: pass");
    end else begin
      $display("pulse_width_one_wire_byte_sender_core regression: fail");
    end
    $finish;
  end

  initial begin
    #(64'd20_000_000);
    $display("pulse_width_one_wire_byte_sender_core regression: fail");
    $finish;
  end

endmodule

// ===== pulse_width_one_wire_byte_sender_core.f =====
sv/pwbs_pkg.sv
sv/pwbs_cfg_regs.sv
sv/pwbs_frame_fsm.sv
sv/pulse_width_one_wire_byte_sender_core.sv
tb/tb.sv
